// ===== hdl/sle_pkg.sv =====
// Shared types, codes and constants for the sorted list engine.
package sle_pkg;

   localparam int VALUE_W = 32;
   localparam int DEFAULT_LIST_DEPTH = 64;

   // Request action codes (req_tuser)
   typedef enum logic [2:0] {
      ACT_INSERT    = 3'd0,
      ACT_DELETE    = 3'd1,
      ACT_REPLACE   = 3'd2,
      ACT_READ_ASC  = 3'd3,
      ACT_READ_DESC = 3'd4
   } action_type;

   // Response status codes (rsp_tuser)
   typedef enum logic [1:0] {
      STAT_OK        = 2'd0,
      STAT_NOT_FOUND = 2'd1,
      STAT_FULL      = 2'd2,
      STAT_EMPTY     = 2'd3
   } status_type;

   // Operation broadcast to every cell of the chain
   typedef enum logic [2:0] {
      CELL_HOLD,
      CELL_INSERT,
      CELL_DELETE,
      CELL_ROT_LEFT,
      CELL_ROT_RIGHT
   } cell_op_type;

   typedef struct packed {
      cell_op_type               op;
      logic signed [VALUE_W-1:0] key;
   } cell_cmd_type;

   typedef enum logic [1:0] {
      SEQ_IDLE,
      SEQ_REPLACE,
      SEQ_READ_ASC,
      SEQ_READ_DESC
   } seq_state_type;

endpackage

// ===== hdl/sle_cell.sv =====
// One storage cell of the sorted chain: holds an entry and trades it with its neighbors.
module sle_cell (
   input  logic                                 clock,
   input  sle_pkg::cell_cmd_type                cmd,
   input  logic                                 cell_valid,
   input  logic signed [sle_pkg::VALUE_W-1:0]   left_value,
   input  logic                                 left_at,
   input  logic signed [sle_pkg::VALUE_W-1:0]   right_value,
   output logic signed [sle_pkg::VALUE_W-1:0]   value,
   output logic                                 at,
   output logic                                 match
);

   logic signed [sle_pkg::VALUE_W-1:0] value_ff;
   logic signed [sle_pkg::VALUE_W-1:0] value_in;

   // Cell lies at or beyond the insert/delete point (list is sorted, so this is monotone)
   assign at    = !cell_valid || !(value_ff < cmd.key);
   assign match = cell_valid && (value_ff == cmd.key);
   assign value = value_ff;

   // Next value from the broadcast operation and the neighbors
   always_comb begin
      case (cmd.op)
         sle_pkg::CELL_INSERT: begin
            if (at) begin
               value_in = left_at ? left_value : cmd.key;
            end else begin
               value_in = value_ff;
            end
         end
         sle_pkg::CELL_DELETE:    value_in = at ? right_value : value_ff;
         sle_pkg::CELL_ROT_LEFT:  value_in = right_value;
         sle_pkg::CELL_ROT_RIGHT: value_in = left_value;
         default:                 value_in = value_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

endmodule

// ===== hdl/sle_seq.sv =====
// Sequencer: request decode, fill count, read rotation counter and response register.
module sle_seq #(
   parameter int LIST_DEPTH = sle_pkg::DEFAULT_LIST_DEPTH,
   parameter int IDX_W      = $clog2(LIST_DEPTH),
   parameter int CNT_W      = $clog2(LIST_DEPTH + 1)
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   input  logic [63:0]                          req_tdata,
   input  logic [2:0]                           req_tuser,
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   output logic [31:0]                          rsp_tdata,
   output logic [1:0]                           rsp_tuser,
   output logic                                 rsp_tlast,
   input  logic                                 found,
   input  logic signed [sle_pkg::VALUE_W-1:0]   head_value,
   input  logic signed [sle_pkg::VALUE_W-1:0]   tail_value,
   output sle_pkg::cell_cmd_type                cmd,
   output logic [CNT_W-1:0]                     count
);

   sle_pkg::seq_state_type state_ff, state_in;
   logic [CNT_W-1:0]       count_ff, count_in;
   logic [IDX_W-1:0]       step_ff, step_in;
   logic signed [sle_pkg::VALUE_W-1:0] new_value_ff, new_value_in;

   logic                   out_valid_ff, out_valid_in;
   logic signed [sle_pkg::VALUE_W-1:0] out_item_ff, out_item_in;
   sle_pkg::status_type    out_status_ff, out_status_in;
   logic                   out_last_ff, out_last_in;

   logic                   out_free;
   logic                   load_out;
   logic                   accept;
   logic                   emit;
   logic                   last_step;
   sle_pkg::action_type    req_action;
   logic signed [sle_pkg::VALUE_W-1:0] req_value;

   assign req_action = sle_pkg::action_type'(req_tuser);
   assign req_value  = req_tdata[31:0];
   assign out_free   = !out_valid_ff || rsp_tready;
   assign req_tready = (state_ff == sle_pkg::SEQ_IDLE) && out_free;
   assign accept     = req_tvalid && req_tready;
   assign last_step  = (step_ff == IDX_W'(LIST_DEPTH - 1));
   assign count      = count_ff;

   // Next state, cell command and response
   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      step_in       = step_ff;
      new_value_in  = new_value_ff;
      cmd.op        = sle_pkg::CELL_HOLD;
      cmd.key       = (state_ff == sle_pkg::SEQ_REPLACE) ? new_value_ff : req_value;
      load_out      = 1'b0;
      out_item_in   = '0;
      out_status_in = sle_pkg::STAT_OK;
      out_last_in   = 1'b1;
      emit          = 1'b0;
      unique case (state_ff)
         sle_pkg::SEQ_IDLE: begin
            if (accept) begin
               unique case (req_action) inside
                  sle_pkg::ACT_INSERT: begin
                     load_out = 1'b1;
                     if (count_ff < CNT_W'(LIST_DEPTH)) begin
                        cmd.op   = sle_pkg::CELL_INSERT;
                        count_in = count_ff + CNT_W'(1);
                     end else begin
                        out_status_in = sle_pkg::STAT_FULL;
                     end
                  end
                  sle_pkg::ACT_DELETE, sle_pkg::ACT_REPLACE: begin
                     load_out = 1'b1;
                     if (found) begin
                        cmd.op   = sle_pkg::CELL_DELETE;
                        count_in = count_ff - CNT_W'(1);
                        if (req_action == sle_pkg::ACT_REPLACE) begin
                           state_in     = sle_pkg::SEQ_REPLACE;
                           new_value_in = req_tdata[63:32];
                        end
                     end else begin
                        out_status_in = sle_pkg::STAT_NOT_FOUND;
                     end
                  end
                  sle_pkg::ACT_READ_ASC, sle_pkg::ACT_READ_DESC: begin
                     if (count_ff == '0) begin
                        load_out      = 1'b1;
                        out_status_in = sle_pkg::STAT_EMPTY;
                     end else begin
                        step_in  = '0;
                        state_in = (req_action == sle_pkg::ACT_READ_ASC) ?
                                   sle_pkg::SEQ_READ_ASC : sle_pkg::SEQ_READ_DESC;
                     end
                  end
                  default: ;
               endcase
            end
         end
         // second half of replace: insert the new value at its sorted place in the list
         sle_pkg::SEQ_REPLACE: begin
            cmd.op   = sle_pkg::CELL_INSERT;
            count_in = count_ff + CNT_W'(1);
            state_in = sle_pkg::SEQ_IDLE;
         end
         // rotate the ring left, entries leave from cell 0 in ascending order
         sle_pkg::SEQ_READ_ASC: begin
            emit = (CNT_W'(step_ff) < count_ff);
            if (!emit || out_free) begin
               cmd.op   = sle_pkg::CELL_ROT_LEFT;
               load_out = emit;
               out_item_in = head_value;
               out_last_in = ((CNT_W'(step_ff) + CNT_W'(1)) == count_ff);
               step_in  = step_ff + IDX_W'(1);
               if (last_step) begin
                  state_in = sle_pkg::SEQ_IDLE;
               end
            end
         end
         // rotate the ring right, entries leave from the last cell in descending order
         sle_pkg::SEQ_READ_DESC: begin
            emit = ((CNT_W+1)'(step_ff) + (CNT_W+1)'(count_ff)) >= (CNT_W+1)'(LIST_DEPTH);
            if (!emit || out_free) begin
               cmd.op   = sle_pkg::CELL_ROT_RIGHT;
               load_out = emit;
               out_item_in = tail_value;
               out_last_in = last_step;
               step_in  = step_ff + IDX_W'(1);
               if (last_step) begin
                  state_in = sle_pkg::SEQ_IDLE;
               end
            end
         end
         default: state_in = sle_pkg::SEQ_IDLE;
      endcase
   end

   // Response register valid
   always_comb begin
      if (load_out) begin
         out_valid_in = 1'b1;
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= sle_pkg::SEQ_IDLE;
         count_ff     <= '0;
         step_ff      <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         step_ff      <= step_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      new_value_ff <= new_value_in;
      if (load_out) begin
         out_item_ff   <= out_item_in;
         out_status_ff <= out_status_in;
         out_last_ff   <= out_last_in;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_item_ff;
   assign rsp_tuser  = out_status_ff;
   assign rsp_tlast  = out_last_ff;

endmodule

// ===== hdl/sorted_list_engine_top.sv =====
// Top level of the sorted list engine: cell chain and sequencer.
//
// Keeps up to LIST_DEPTH signed 32-bit entries in ascending order (duplicates allowed)
// in a ring of cells that compare against a broadcast key and shift in parallel.
// Insert and delete each give one response; replace runs a delete and then, from the
// replace state, an insert, and gives one response; an unknown action is taken and
// dropped without a response. A read of a non-empty list rotates the whole ring once,
// so it holds the request port for the whole rotation and while the response side
// stalls, emitting each entry from the ring's head (ascending) or tail
// (descending) with tlast on the final one; a read of an empty list gives one
// response with status empty. A new request is taken only when the response
// register is empty or its response transfers in that same cycle, so back-to-back
// updates need rsp_tready held high. No clearing pass runs after reset.
module sorted_list_engine_top #(
   parameter int LIST_DEPTH = sle_pkg::DEFAULT_LIST_DEPTH
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [63:0] req_tdata,   // [31:0] value, [63:32] new_value
   input  logic [2:0]  req_tuser,   // [2:0] action
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // [31:0] item
   output logic [1:0]  rsp_tuser,   // [1:0] status
   output logic        rsp_tlast
);

   localparam int IDX_W = $clog2(LIST_DEPTH);
   localparam int CNT_W = $clog2(LIST_DEPTH + 1);

   sle_pkg::cell_cmd_type                cmd;
   logic [CNT_W-1:0]                     count;
   logic signed [sle_pkg::VALUE_W-1:0]   cell_value [LIST_DEPTH];
   logic [LIST_DEPTH-1:0]                cell_at;
   logic [LIST_DEPTH-1:0]                cell_match;
   logic                                 found;

   assign found = |cell_match;

   // Ring of cells: cell 0 wraps to the last cell
   for (genvar i = 0; i < LIST_DEPTH; i++) begin : g_cell
      sle_cell u_cell (
         .clock       (clock),
         .cmd         (cmd),
         .cell_valid  (CNT_W'(i) < count),
         .left_value  (cell_value[(i + LIST_DEPTH - 1) % LIST_DEPTH]),
         .left_at     ((i == 0) ? 1'b0 : cell_at[(i + LIST_DEPTH - 1) % LIST_DEPTH]),
         .right_value (cell_value[(i + 1) % LIST_DEPTH]),
         .value       (cell_value[i]),
         .at          (cell_at[i]),
         .match       (cell_match[i])
      );
   end

   sle_seq #(
      .LIST_DEPTH (LIST_DEPTH),
      .IDX_W      (IDX_W),
      .CNT_W      (CNT_W)
   ) u_seq (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .found      (found),
      .head_value (cell_value[0]),
      .tail_value (cell_value[LIST_DEPTH-1]),
      .cmd        (cmd),
      .count      (count)
   );

endmodule

// ===== dv/sorted_list_engine_top_tb.sv =====
// Self-checking testbench for the sorted list engine: stream stimulus, list predictor, scoreboard.
`timescale 1ns / 1ps

module sorted_list_engine_top_tb;

   localparam int LIST_DEPTH = sle_pkg::DEFAULT_LIST_DEPTH;
   localparam int MAX_REPORTS = 10;
   localparam int WATCHDOG_LIMIT = 4000;
   localparam int RESET_CYCLES = 11;

   // action codes the block takes and drops without a response
   localparam logic [2:0] ACT_SPARE_FIRST = 3'd5;
   localparam logic [2:0] ACT_SPARE_LAST = 3'd7;

   typedef logic signed [sle_pkg::VALUE_W-1:0] list_value_type;

   typedef struct packed {
      list_value_type      item;
      sle_pkg::status_type status;
      logic                last;
   } list_result_type;

   typedef enum int {
      TRAFFIC_FILL,
      TRAFFIC_DRAIN,
      TRAFFIC_BALANCED
   } traffic_mode_type;

   // Ordered list predictor plus queue of pending responses
   class list_scoreboard;
      list_value_type  entries[$];
      list_result_type pending_results[$];
      int              depth;
      int              mismatches;
      int              checked;
      int              requests;
      int              reads;
      int              spares;
      int              full_count;
      int              not_found_count;
      int              empty_count;
      int              peak_fill;

      function new(int list_depth);
         depth = list_depth;
      endfunction

      function int pending();
         return pending_results.size();
      endfunction

      function void push_result(list_value_type item, sle_pkg::status_type status,
                                logic last);
         list_result_type r;
         r.item = item;
         r.status = status;
         r.last = last;
         pending_results.push_back(r);
         case (status)
            sle_pkg::STAT_FULL:      full_count++;
            sle_pkg::STAT_NOT_FOUND: not_found_count++;
            sle_pkg::STAT_EMPTY:     empty_count++;
            default: ;
         endcase
      endfunction

      // new value goes in front of the first entry that is not smaller
      function bit place_value(list_value_type v);
         int pos;
         if (entries.size() >= depth) return 1'b0;
         pos = 0;
         while (pos < entries.size() && entries[pos] < v) pos++;
         entries.insert(pos, v);
         return 1'b1;
      endfunction

      function int find_value(list_value_type v);
         foreach (entries[i]) begin
            if (entries[i] == v) return i;
         end
         return -1;
      endfunction

      // accepted request: update the list and queue the responses it causes
      function void note_request(logic [2:0] act, list_value_type value,
                                 list_value_type new_value);
         int pos;
         int n;
         requests++;
         case (act)
            sle_pkg::ACT_INSERT: begin
               push_result('0, place_value(value) ? sle_pkg::STAT_OK : sle_pkg::STAT_FULL,
                           1'b1);
            end
            sle_pkg::ACT_DELETE, sle_pkg::ACT_REPLACE: begin
               pos = find_value(value);
               if (pos < 0) begin
                  push_result('0, sle_pkg::STAT_NOT_FOUND, 1'b1);
               end else begin
                  entries.delete(pos);
                  if (act == sle_pkg::ACT_REPLACE) void'(place_value(new_value));
                  push_result('0, sle_pkg::STAT_OK, 1'b1);
               end
            end
            sle_pkg::ACT_READ_ASC, sle_pkg::ACT_READ_DESC: begin
               reads++;
               n = entries.size();
               if (n == 0) begin
                  push_result('0, sle_pkg::STAT_EMPTY, 1'b1);
               end else begin
                  for (int i = 0; i < n; i++) begin
                     push_result(entries[(act == sle_pkg::ACT_READ_ASC) ? i : n - 1 - i],
                                 sle_pkg::STAT_OK, i == n - 1);
                  end
               end
            end
            default: spares++;
         endcase
         if (entries.size() > peak_fill) peak_fill = entries.size();
      endfunction

      function void log_mismatch(string what, list_result_type want, list_value_type item,
                                 logic [1:0] status, logic last);
         mismatches++;
         if (mismatches <= MAX_REPORTS)
            $display({"%t MISMATCH %s: expected item %0d status %0d last %0b,",
                      " got item %0d status %0d last %0b"},
                     $realtime, what, want.item, want.status, want.last, item, status, last);
      endfunction

      // response transfer: compare with the oldest pending result
      function void check_response(list_value_type item, logic [1:0] status, logic last);
         list_result_type want;
         checked++;
         if (pending_results.size() == 0) begin
            want = '0;
            log_mismatch("unexpected response", want, item, status, last);
            return;
         end
         want = pending_results.pop_front();
         if (item !== want.item || status !== want.status || last !== want.last)
            log_mismatch("response", want, item, status, last);
      endfunction

      function void flag_leftovers();
         while (pending_results.size() != 0)
            log_mismatch("missing response", pending_results.pop_front(), 'x, 'x, 'x);
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [63:0] req_tdata = '0;   // [31:0] value, [63:32] new_value
   logic [2:0]  req_tuser = '0;   // [2:0] action
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;        // [31:0] item
   logic [1:0]  rsp_tuser;        // [1:0] status
   logic        rsp_tlast;

   bit             quiet_mode = 1'b0;
   int             stall_left = 0;
   list_scoreboard sb;

   sorted_list_engine_top #(
      .LIST_DEPTH(LIST_DEPTH)
   ) u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Monitor both channels on the values sampled before the edge
   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready)
            sb.note_request(req_tuser, req_tdata[31:0], req_tdata[63:32]);
         if (rsp_tvalid && rsp_tready)
            sb.check_response(rsp_tdata, rsp_tuser, rsp_tlast);
      end
   end

   // Response side backpressure: short random stalls, now and then a long one
   always @(posedge clock) begin
      if (quiet_mode) begin
         rsp_tready <= 1'b1;
      end else if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_tready <= 1'b0;
      end else if ($urandom_range(0, 99) < 4) begin
         stall_left <= $urandom_range(10, 40);
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(0, 99) < 75);
      end
   end

   // Watchdog: ends the run when no transfer happens for too long
   initial begin : watchdog
      int quiet_cycles;
      quiet_cycles = 0;
      while (quiet_cycles < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
            quiet_cycles = 0;
         else
            quiet_cycles++;
      end
      $display("Watchdog: no transfer for %0d cycles", WATCHDOG_LIMIT);
      $display("Verification failed");
      $finish;
   end

   function automatic int pick_gap();
      int r;
      if (quiet_mode) return 0;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   // One request transfer; valid stays high across back-to-back requests
   task automatic send_request(input logic [2:0] act, input list_value_type value,
                               input list_value_type new_value);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= act;
      req_tdata <= {new_value, value};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   // Sender holds off until every pending response has arrived
   task automatic hold_until_drained();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (sb.pending() != 0) @(posedge clock);
   endtask

   function automatic list_value_type pick_value();
      int r;
      r = $urandom_range(0, 99);
      if (r < 45) return $signed($urandom_range(0, 15)) - 8;
      if (r < 55) begin
         case ($urandom_range(0, 5))
            0: return 32'sh8000_0000;
            1: return 32'sh7FFF_FFFF;
            2: return 32'sh8000_0001;
            3: return 32'sh7FFF_FFFE;
            4: return -1;
            default: return 0;
         endcase
      end
      if (r < 75 && sb.entries.size() != 0)
         return sb.entries[$urandom_range(0, sb.entries.size() - 1)];
      return $urandom;
   endfunction

   // mostly a stored value so deletes and replaces hit
   function automatic list_value_type pick_target();
      if (sb.entries.size() != 0 && $urandom_range(0, 99) < 65)
         return sb.entries[$urandom_range(0, sb.entries.size() - 1)];
      return pick_value();
   endfunction

   task automatic run_traffic(input traffic_mode_type mode, input int count);
      int             r;
      int             cut[5];
      logic [2:0]     act;
      list_value_type value;
      list_value_type new_value;
      // cumulative percentages: insert, delete, replace, read asc, read desc, rest spare
      case (mode)
         TRAFFIC_FILL:  cut = '{86, 89, 92, 95, 98};
         TRAFFIC_DRAIN: cut = '{15, 65, 85, 91, 97};
         default:       cut = '{40, 62, 80, 88, 96};
      endcase
      for (int n = 0; n < count; n++) begin
         r = $urandom_range(0, 99);
         if (r < cut[0])      act = sle_pkg::ACT_INSERT;
         else if (r < cut[1]) act = sle_pkg::ACT_DELETE;
         else if (r < cut[2]) act = sle_pkg::ACT_REPLACE;
         else if (r < cut[3]) act = sle_pkg::ACT_READ_ASC;
         else if (r < cut[4]) act = sle_pkg::ACT_READ_DESC;
         else                 act = 3'($urandom_range(ACT_SPARE_FIRST, ACT_SPARE_LAST));
         value = (act == sle_pkg::ACT_INSERT) ? pick_value() : pick_target();
         new_value = (act == sle_pkg::ACT_REPLACE || $urandom_range(0, 1)) ?
                     pick_value() : $urandom;
         if ($urandom_range(0, 99) < 3) hold_until_drained();
         send_request(act, value, new_value);
      end
   endtask

   initial begin
      sb = new(LIST_DEPTH);
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // Directed: empty reads, misses, extremes, duplicates, head and only-entry deletes
      send_request(sle_pkg::ACT_READ_ASC, 0, 0);
      send_request(sle_pkg::ACT_READ_DESC, 0, 0);
      send_request(sle_pkg::ACT_DELETE, 5, 0);
      send_request(sle_pkg::ACT_REPLACE, 5, 7);
      send_request(sle_pkg::ACT_INSERT, 32'sh7FFF_FFFF, 0);
      send_request(sle_pkg::ACT_INSERT, 32'sh8000_0000, 32'sh7FFF_FFFF);
      send_request(sle_pkg::ACT_INSERT, 0, -1);
      send_request(sle_pkg::ACT_INSERT, -1, 0);
      send_request(sle_pkg::ACT_INSERT, 0, 0);
      send_request(sle_pkg::ACT_READ_ASC, 0, 0);
      send_request(sle_pkg::ACT_READ_DESC, 0, 0);
      for (int c = ACT_SPARE_FIRST; c <= ACT_SPARE_LAST; c++)
         send_request(c[2:0], 32'sh7FFF_FFFF, 32'sh8000_0000);
      send_request(sle_pkg::ACT_DELETE, 32'sh8000_0000, 0);
      send_request(sle_pkg::ACT_REPLACE, 0, 32'sh8000_0000);
      send_request(sle_pkg::ACT_REPLACE, 100, 3);
      send_request(sle_pkg::ACT_DELETE, -1, 0);
      send_request(sle_pkg::ACT_DELETE, 0, 0);
      send_request(sle_pkg::ACT_DELETE, 32'sh7FFF_FFFF, 0);
      send_request(sle_pkg::ACT_READ_ASC, 0, 0);
      send_request(sle_pkg::ACT_DELETE, 32'sh8000_0000, 0);
      send_request(sle_pkg::ACT_READ_DESC, 0, 0);
      send_request(sle_pkg::ACT_INSERT, 3, 0);
      send_request(sle_pkg::ACT_READ_DESC, 0, 0);
      hold_until_drained();

      // Random: fill past capacity, steady mixed stretch, drain, then mixed again
      run_traffic(TRAFFIC_FILL, 90);
      hold_until_drained();
      quiet_mode = 1'b1;
      run_traffic(TRAFFIC_BALANCED, 50);
      quiet_mode = 1'b0;
      run_traffic(TRAFFIC_DRAIN, 80);
      run_traffic(TRAFFIC_BALANCED, 60);

      // Wind down and let any stray response show up
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (sb.pending() != 0) @(posedge clock);
      repeat (LIST_DEPTH + 16) @(posedge clock);
      sb.flag_leftovers();

      $display("Covered %0d requests (%0d reads, %0d spare action codes), %0d responses checked",
               sb.requests, sb.reads, sb.spares, sb.checked);
      $display("Rejected as full %0d, not found %0d, empty reads %0d, peak occupancy %0d of %0d",
               sb.full_count, sb.not_found_count, sb.empty_count, sb.peak_fill, LIST_DEPTH);
      if (sb.mismatches == 0) begin
         $display("Verification passed");
      end else begin
         $display("%0d mismatches in total", sb.mismatches);
         $display("Verification failed");
      end
      $finish;
   end

endmodule

// ===== files.f =====
hdl/sle_pkg.sv
hdl/sle_cell.sv
hdl/sle_seq.sv
hdl/sorted_list_engine_top.sv
dv/sorted_list_engine_top_tb.sv
